// ----- src/rbb_pkg.sv -----
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared constants and types for the RGB box blur pipeline.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int RADIUS_DEFAULT         = 8;
  localparam int MAX_ROW_LENGTH_DEFAULT = 4096;
  localparam int ROW_LENGTH_RESET       = 4096;
  localparam int ROW_LENGTH_W           = 13;
  localparam int PIX_W                  = 8;
  localparam int CHANNELS               = 3;
  localparam int PIX_MAX                = (1 << PIX_W) - 1;

  // Channel 0 is red, 1 is green, 2 is blue.
  typedef logic [CHANNELS-1:0][PIX_W-1:0] rgb_t;

  typedef struct packed {
    logic first_col;
    logic drop_col;
    logic first_row;
    logic filling;
    logic emit;
    logic last;
  } rbb_ctl_t;

endpackage

// ----- src/rbb_position.sv -----
// ----------------------------------------------------------------------------
// rbb_position
// Row length register and the column, row and line slot counters.
// ----------------------------------------------------------------------------
module rbb_position import rbb_pkg::*; #(
  parameter int RADIUS         = RADIUS_DEFAULT,
  parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                row_length_we,
  input  logic [ROW_LENGTH_W-1:0]             row_length,
  input  logic                                frame_start,
  input  logic                                acc,
  output logic [$clog2(MAX_ROW_LENGTH)-1:0]   col,
  output logic [$clog2(2*RADIUS+1)-1:0]       slot,
  output rbb_ctl_t                            ctl
);

  localparam int K      = 2 * RADIUS + 1;
  localparam int POS_W  = $clog2(MAX_ROW_LENGTH);
  localparam int SLOT_W = $clog2(K);
  localparam int RS_W   = $clog2(K + 1);
  localparam int LEN_W  = $clog2(MAX_ROW_LENGTH + 1);
  localparam int CMP_W  = (LEN_W > ROW_LENGTH_W) ? LEN_W : ROW_LENGTH_W;
  localparam int LEN_RESET =
    (ROW_LENGTH_RESET > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : ROW_LENGTH_RESET;

  logic [LEN_W-1:0]  len;
  logic [POS_W-1:0]  column_position;
  logic [RS_W-1:0]   rows_seen;
  logic [SLOT_W-1:0] row_slot;

  logic [CMP_W-1:0]  cfg_ext;
  logic [LEN_W-1:0]  len_next;
  logic [RS_W-1:0]   rs0;
  logic [LEN_W-1:0]  c_inc;

  assign cfg_ext = CMP_W'(row_length);

  always_comb begin
    if (cfg_ext < CMP_W'(K)) begin
      len_next = LEN_W'(K);
    end else if (cfg_ext > CMP_W'(MAX_ROW_LENGTH)) begin
      len_next = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len_next = LEN_W'(cfg_ext);
    end
  end

  assign col   = frame_start ? '0 : column_position;
  assign rs0   = frame_start ? '0 : rows_seen;
  assign slot  = frame_start ? '0 : row_slot;
  assign c_inc = LEN_W'(col) + LEN_W'(1);

  assign ctl.first_col = (col == '0);
  assign ctl.drop_col  = (col >= POS_W'(K));
  assign ctl.first_row = (rs0 == '0);
  assign ctl.filling   = (rs0 < RS_W'(K));
  assign ctl.emit      = (rs0 >= RS_W'(K - 1)) && (col >= POS_W'(K - 1));
  assign ctl.last      = (c_inc >= len);

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_W'(LEN_RESET);
    end else if (row_length_we) begin
      len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      rows_seen       <= '0;
      row_slot        <= '0;
    end else if (acc) begin
      if (ctl.last) begin
        column_position <= '0;
        rows_seen       <= ctl.filling ? rs0 + RS_W'(1) : rs0;
        row_slot        <= (slot == SLOT_W'(K - 1)) ? '0 : slot + SLOT_W'(1);
      end else begin
        column_position <= POS_W'(c_inc);
        rows_seen       <= rs0;
        row_slot        <= slot;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    acc && ctl.last |=> column_position == '0)
    else $error("column position did not wrap after the last word of a row");

  a_rows_sat: assert property (@(posedge clk) disable iff (rst)
    rows_seen <= RS_W'(K))
    else $error("row count passed the window height");

  a_emit_ctx: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> !ctl.first_col && !ctl.first_row)
    else $error("result requested at the first row or column");
`endif

endmodule

// ----- src/rbb_column_store.sv -----
// ----------------------------------------------------------------------------
// rbb_column_store
// Line store ring and per-column running sums over the last rows.
// ----------------------------------------------------------------------------
module rbb_column_store import rbb_pkg::*; #(
  parameter int RADIUS         = RADIUS_DEFAULT,
  parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEFAULT
) (
  input  logic                                                  clk,
  input  logic                                                  rd_en,
  input  logic [$clog2(2*RADIUS+1)-1:0]                         rd_slot,
  input  logic [$clog2(MAX_ROW_LENGTH)-1:0]                     rd_col,
  input  logic                                                  wr_en,
  input  logic [$clog2(2*RADIUS+1)-1:0]                         wr_slot,
  input  logic [$clog2(MAX_ROW_LENGTH)-1:0]                     wr_col,
  input  rgb_t                                                  pix,
  input  rbb_ctl_t                                              ctl,
  output logic [CHANNELS-1:0][$clog2((2*RADIUS+1)*PIX_MAX+1)-1:0] csum
);

  localparam int K      = 2 * RADIUS + 1;
  localparam int CSUM_W = $clog2(K * PIX_MAX + 1);

  typedef logic [CHANNELS-1:0][CSUM_W-1:0] csum_t;

  rgb_t  line_mem [K][MAX_ROW_LENGTH];
  csum_t sum_mem  [MAX_ROW_LENGTH];
  rgb_t  old_pix;
  csum_t old_sum;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      old_pix <= line_mem[rd_slot][rd_col];
    end
    if (wr_en) begin
      line_mem[wr_slot][wr_col] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      old_sum <= sum_mem[rd_col];
    end
    if (wr_en) begin
      sum_mem[wr_col] <= csum;
    end
  end

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (ctl.first_row) begin
        csum[ch] = CSUM_W'(pix[ch]);
      end else if (ctl.filling) begin
        csum[ch] = old_sum[ch] + CSUM_W'(pix[ch]);
      end else begin
        csum[ch] = old_sum[ch] + CSUM_W'(pix[ch]) - CSUM_W'(old_pix[ch]);
      end
    end
  end

endmodule

// ----- src/rbb_window.sv -----
// ----------------------------------------------------------------------------
// rbb_window
// Sliding sum over the most recent column sums of the current row.
// ----------------------------------------------------------------------------
module rbb_window import rbb_pkg::*; #(
  parameter int RADIUS = RADIUS_DEFAULT
) (
  input  logic                                                    clk,
  input  logic                                                    adv,
  input  rbb_ctl_t                                                ctl,
  input  logic [CHANNELS-1:0][$clog2((2*RADIUS+1)*PIX_MAX+1)-1:0] csum,
  output logic [CHANNELS-1:0][$clog2((2*RADIUS+1)*(2*RADIUS+1)*PIX_MAX+1)-1:0] wsum,
  output logic                                                    row_end
);

  localparam int K      = 2 * RADIUS + 1;
  localparam int CSUM_W = $clog2(K * PIX_MAX + 1);
  localparam int WSUM_W = $clog2(K * K * PIX_MAX + 1);

  typedef logic [CHANNELS-1:0][CSUM_W-1:0] csum_t;
  typedef logic [CHANNELS-1:0][WSUM_W-1:0] wsum_t;

  csum_t recent [K];
  wsum_t window;
  wsum_t window_next;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      window_next[ch] = (ctl.first_col ? '0 : window[ch])
                      - (ctl.drop_col ? WSUM_W'(recent[K-1][ch]) : '0)
                      + WSUM_W'(csum[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      window    <= window_next;
      wsum      <= window_next;
      row_end   <= ctl.last;
      recent[0] <= csum;
      for (int i = 1; i < K; i++) begin
        recent[i] <= recent[i-1];
      end
    end
  end

endmodule

// ----- src/rbb_divide.sv -----
// ----------------------------------------------------------------------------
// rbb_divide
// Window sum to mean by a constant reciprocal multiply, registered output.
// ----------------------------------------------------------------------------
module rbb_divide import rbb_pkg::*; #(
  parameter int RADIUS = RADIUS_DEFAULT
) (
  input  logic                                                    clk,
  input  logic                                                    load,
  input  logic [CHANNELS-1:0][$clog2((2*RADIUS+1)*(2*RADIUS+1)*PIX_MAX+1)-1:0] wsum,
  input  logic                                                    row_end_in,
  output rgb_t                                                    mean,
  output logic                                                    row_end
);

  localparam int K         = 2 * RADIUS + 1;
  localparam int AREA      = K * K;
  localparam int WSUM_W    = $clog2(AREA * PIX_MAX + 1);
  localparam int DIV_SHIFT = WSUM_W + $clog2(AREA);
  localparam int RECIP_W   = WSUM_W + 2;
  localparam int PROD_W    = WSUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(AREA) - 64'd1) / 64'(AREA));

  logic [CHANNELS-1:0][PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        prod[ch] <= PROD_W'(wsum[ch]) * PROD_W'(RECIP);
      end
      row_end <= row_end_in;
    end
  end

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      mean[ch] = prod[ch][DIV_SHIFT +: PIX_W];
    end
  end

endmodule

// ----- src/rgb_box_blur_17x17.sv -----
// ----------------------------------------------------------------------------
// rgb_box_blur_17x17
// Streaming box blur over a square window on padded RGB pixel words.
// ----------------------------------------------------------------------------
// A result word is valid once its input word has passed the input, window sum
// and divide registers. Throughput: one word per cycle unless m_tready stalls.
// Reset clears the pipeline valids, the row position and the row count and
// loads the row length register with 4096; line and column stores keep data.
module rgb_box_blur_17x17 import rbb_pkg::*; #(
  parameter int RADIUS         = RADIUS_DEFAULT,
  parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    row_length_we,
  input  logic [ROW_LENGTH_W-1:0] row_length,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [23:0]             s_tdata,  // red_in, green_in, blue_in
  input  logic                    s_tuser,  // frame_start
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [23:0]             m_tdata,  // red_out, green_out, blue_out
  output logic                    m_tlast   // row_end
);

  localparam int K      = 2 * RADIUS + 1;
  localparam int POS_W  = $clog2(MAX_ROW_LENGTH);
  localparam int SLOT_W = $clog2(K);
  localparam int CSUM_W = $clog2(K * PIX_MAX + 1);
  localparam int WSUM_W = $clog2(K * K * PIX_MAX + 1);

  logic en1, en2, en3, acc, adv1;
  logic v1, v2, v3;

  logic [POS_W-1:0]  col0;
  logic [SLOT_W-1:0] slot0;
  rbb_ctl_t          ctl0;

  rgb_t              pix1;
  rbb_ctl_t          ctl1;
  logic [POS_W-1:0]  col1;
  logic [SLOT_W-1:0] slot1;

  logic [CHANNELS-1:0][CSUM_W-1:0] csum1;
  logic [CHANNELS-1:0][WSUM_W-1:0] wsum2;
  logic                            row_end2;
  rgb_t                            mean3;

  assign en3      = !v3 || m_tready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign acc      = s_tvalid && en1;
  assign adv1     = v1 && en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= acc;
      end
      if (en2) begin
        v2 <= v1 && ctl1.emit;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pix1  <= s_tdata;
      ctl1  <= ctl0;
      col1  <= col0;
      slot1 <= slot0;
    end
  end

  rbb_position #(
    .RADIUS         (RADIUS),
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_position (
    .clk           (clk),
    .rst           (rst),
    .row_length_we (row_length_we),
    .row_length    (row_length),
    .frame_start   (s_tuser),
    .acc           (acc),
    .col           (col0),
    .slot          (slot0),
    .ctl           (ctl0)
  );

  rbb_column_store #(
    .RADIUS         (RADIUS),
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_column_store (
    .clk     (clk),
    .rd_en   (en1),
    .rd_slot (slot0),
    .rd_col  (col0),
    .wr_en   (adv1),
    .wr_slot (slot1),
    .wr_col  (col1),
    .pix     (pix1),
    .ctl     (ctl1),
    .csum    (csum1)
  );

  rbb_window #(
    .RADIUS (RADIUS)
  ) u_window (
    .clk     (clk),
    .adv     (adv1),
    .ctl     (ctl1),
    .csum    (csum1),
    .wsum    (wsum2),
    .row_end (row_end2)
  );

  rbb_divide #(
    .RADIUS (RADIUS)
  ) u_divide (
    .clk        (clk),
    .load       (en3),
    .wsum       (wsum2),
    .row_end_in (row_end2),
    .mean       (mean3),
    .row_end    (m_tlast)
  );

  assign m_tvalid = v3;
  assign m_tdata  = mean3;

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v1 && v2 && m_tvalid && !m_tready)
    else $error("input stalled while the pipeline has room");
`endif

endmodule

// ----- verif/rgb_box_blur_17x17_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_box_blur_17x17_tb
// Self-checking bench for the streaming 17x17 RGB box blur. Padded frames are
// streamed through the slave side under random stalls on both sides. A
// bit-accurate running-sum predictor builds the expected blurred words, and the
// monitor checks them in order on the master side. Row lengths are changed
// between frames, including clamped values and a shrink in the middle of a row.
// ----------------------------------------------------------------------------
module rgb_box_blur_17x17_tb;
  import rbb_pkg::*;

  localparam int KSIZE         = 2 * RADIUS_DEFAULT + 1;
  localparam int AREA          = KSIZE * KSIZE;
  localparam int MAX_LEN       = MAX_ROW_LENGTH_DEFAULT;
  localparam int LATENCY       = 3;
  localparam int SETTLE_CYCLES = LATENCY + 5;
  localparam int HOLD_CYCLES   = 150;
  localparam int MODE_A_END    = 500;
  localparam int MODE_B_END    = 1000;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    rgb_t rgb;
    logic frame_start;
  } pixel_t;

  typedef struct {
    rgb_t rgb;
    logic row_end;
  } blurred_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    row_length_we = 1'b0;
  logic [ROW_LENGTH_W-1:0] row_length = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [23:0]             s_tdata = '0;  // red_in, green_in, blue_in
  logic                    s_tuser = 1'b0;  // frame_start
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [23:0]             m_tdata;  // red_out, green_out, blue_out
  logic                    m_tlast;  // row_end

  rgb_box_blur_17x17 dut (
    .clk           (clk),
    .rst           (rst),
    .row_length_we (row_length_we),
    .row_length    (row_length),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

  always #4 clk = ~clk;

  // Predictor state for the running-sum blur.
  bit [23:0]        line_mem [KSIZE][MAX_LEN];
  bit [12:0]        col_sum [MAX_LEN][CHANNELS];
  bit [12:0]        recent_sum [KSIZE][CHANNELS];
  bit [16:0]        win_sum [CHANNELS];
  int unsigned      col_pos;
  int unsigned      rows_done;
  int unsigned      ring_row;
  bit [12:0]        len_reg;

  pixel_t           pending_px[$];
  blurred_t         expected_blur[$];
  int unsigned      queued = 0;
  int unsigned      accepted = 0;
  int unsigned      results_seen = 0;
  int unsigned      cfg_writes = 0;
  int unsigned      err_count = 0;
  int unsigned      cycles = 0;
  int unsigned      hold_req_cnt = 0;
  int unsigned      hold_ack_cnt = 0;
  int unsigned      hold_left = 0;
  logic             s_taken = 1'b0;
  string            chan_name [CHANNELS] = '{"red_out", "green_out", "blue_out"};

  function automatic bit blur_step(input rgb_t px, input bit fs, output blurred_t res);
    int unsigned len;
    int unsigned c;
    int unsigned slot;
    int unsigned ring;
    int unsigned mean;
    bit [23:0]   prev;
    bit [16:0]   w;
    bit          hit;
    len = len_reg;
    if (len < KSIZE) len = KSIZE;
    if (len > MAX_LEN) len = MAX_LEN;
    if (fs) begin
      col_pos   = 0;
      rows_done = 0;
      ring_row  = 0;
    end
    c    = (col_pos >= MAX_LEN) ? MAX_LEN - 1 : col_pos;
    slot = ring_row % KSIZE;
    ring = c % KSIZE;
    prev = line_mem[slot][c];
    for (int k = 0; k < CHANNELS; k++) begin
      if (rows_done == 0) begin
        col_sum[c][k] = px[k];
      end else if (rows_done < KSIZE) begin
        col_sum[c][k] = col_sum[c][k] + px[k];
      end else begin
        col_sum[c][k] = col_sum[c][k] + px[k] - prev[8*k +: 8];
      end
    end
    line_mem[slot][c] = px;
    for (int k = 0; k < CHANNELS; k++) begin
      w = (c == 0) ? '0 : win_sum[k];
      if (c >= KSIZE) w = w - recent_sum[ring][k];
      w = w + col_sum[c][k];
      win_sum[k] = w;
      recent_sum[ring][k] = col_sum[c][k];
      mean = win_sum[k] / AREA;
      res.rgb[k] = mean[7:0];
    end
    res.row_end = (c + 1 >= len);
    hit = (rows_done >= KSIZE - 1) && (c >= KSIZE - 1);
    if (res.row_end) begin
      col_pos = 0;
      if (rows_done < KSIZE) rows_done++;
      ring_row = (slot + 1) % KSIZE;
    end else begin
      col_pos = c + 1;
    end
    return hit;
  endfunction

  function automatic int send_idle_pct();
    if (accepted < MODE_A_END) return 30;
    if (accepted < MODE_B_END) return 48;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted < MODE_A_END) return 48;
    if (accepted < MODE_B_END) return 30;
    return 0;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("rgb_box_blur_17x17_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      hold_left    <= HOLD_CYCLES;
      hold_ack_cnt <= hold_req_cnt;
    end
  end

  always @(negedge clk) begin : drive_px
    pixel_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (pending_px.size() != 0 && $urandom_range(99, 0) >= send_idle_pct()) begin
        nxt = pending_px.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.rgb;
        s_tuser  <= nxt.frame_start;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin : track
    blurred_t res;
    blurred_t want;
    if (rst) begin
      s_taken   <= 1'b0;
      len_reg   = ROW_LENGTH_RESET;
      col_pos   = 0;
      rows_done = 0;
      ring_row  = 0;
      foreach (win_sum[k]) win_sum[k] = '0;
      foreach (recent_sum[i, k]) recent_sum[i][k] = '0;
    end else begin
      s_taken <= s_tvalid && s_tready;
      if (row_length_we) begin
        len_reg = row_length;
        cfg_writes++;
      end
      if (s_tvalid && s_tready) begin
        accepted++;
        if (blur_step(s_tdata, s_tuser, res)) expected_blur = {expected_blur, res};
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_blur.size() == 0) begin
          $error("unexpected blurred word %h last %b", m_tdata, m_tlast);
          err_count++;
        end else begin
          want = expected_blur.pop_front();
          for (int k = 0; k < CHANNELS; k++) begin
            if (m_tdata[8*k +: 8] !== want.rgb[k]) begin
              $error("%s expected %0d actual %0d", chan_name[k], want.rgb[k],
                     m_tdata[8*k +: 8]);
              err_count++;
            end
          end
          if (m_tlast !== want.row_end) begin
            $error("row_end expected %0d actual %0d", want.row_end, m_tlast);
            err_count++;
          end
        end
      end
    end
  end

  task automatic queue_one(bit fs, int lo, int hi);
    pixel_t p;
    for (int k = 0; k < CHANNELS; k++) p.rgb[k] = $urandom_range(hi, lo);
    p.frame_start = fs;
    pending_px = {pending_px, p};
    queued++;
  endtask

  task automatic queue_pixels(int count, bit restart, int lo, int hi);
    for (int i = 0; i < count; i++) queue_one(restart && i == 0, lo, hi);
  endtask

  task automatic queue_word(logic [23:0] data, bit fs);
    pixel_t p;
    p.rgb         = data;
    p.frame_start = fs;
    pending_px = {pending_px, p};
    queued++;
  endtask

  task automatic wait_accepted;
    while (accepted != queued) @(posedge clk);
  endtask

  task automatic wait_drained;
    while (accepted != queued || expected_blur.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_row_length(int unsigned value);
    @(negedge clk);
    row_length_we <= 1'b1;
    row_length    <= value[ROW_LENGTH_W-1:0];
    @(negedge clk);
    row_length_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned rand_items;
    int unsigned len_val;
    int unsigned eff;
    int unsigned rows;
    int unsigned total;
    int          restart_at;
    int          lo;
    int          hi;
    rand_items = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset row length, a handful of corner words and a restart in the middle.
    queue_word(24'h000000, 1'b0);
    queue_word(24'hFFFFFF, 1'b0);
    queue_word(24'h55AA55, 1'b0);
    queue_word(24'hAA55AA, 1'b0);
    queue_word(24'hF0F0F0, 1'b1);
    queue_word(24'h0F0F0F, 1'b0);
    queue_word(24'h123456, 1'b0);
    queue_word(24'hFEDCBA, 1'b0);
    wait_drained();

    // A zero row length clamps up to the window size; saturated then cleared.
    set_row_length(0);
    queue_pixels(KSIZE * KSIZE, 1'b1, 255, 255);
    queue_pixels(KSIZE, 1'b0, 0, 0);
    wait_drained();
    set_row_length(KSIZE - 1);
    queue_pixels(KSIZE * KSIZE, 1'b1, 0, 0);
    wait_drained();

    // Fill 16 rows, pause until drained, then stall the output for a long time.
    set_row_length(24);
    queue_pixels(16 * 24, 1'b1, 0, 255);
    wait_drained();
    @(negedge clk);
    hold_req_cnt++;
    queue_pixels(24 + 20, 1'b0, 0, 255);
    wait_drained();
    // Shrinking below the current column ends the row on the next word.
    set_row_length(18);
    queue_pixels(1 + 3 * 18 + 10, 1'b0, 0, 255);
    queue_pixels(12, 1'b1, 0, 255);
    wait_drained();

    while (rand_items < 250 || results_seen < 60) begin
      case ($urandom_range(9, 0))
        0: len_val = $urandom_range(8191, MAX_LEN);
        1: len_val = $urandom_range(KSIZE - 1, 0);
        default: len_val = $urandom_range(28, KSIZE);
      endcase
      eff = (len_val < KSIZE) ? KSIZE : (len_val > MAX_LEN) ? MAX_LEN : len_val;
      wait_drained();
      set_row_length(len_val);
      if (eff > 64) begin
        total = $urandom_range(60, 20);
        queue_pixels(total, 1'b1, 0, 255);
      end else begin
        rows = $urandom_range(KSIZE + 3, KSIZE);
        total = rows * eff;
        if ($urandom_range(7, 0) == 0) total = $urandom_range(total - 1, 1);
        restart_at = ($urandom_range(5, 0) == 0) ? $urandom_range(total - 1, 1) : -1;
        if ($urandom_range(5, 0) == 0) begin
          lo = $urandom_range(1, 0) * 255;
          hi = lo;
        end else begin
          lo = $urandom_range(255, 0);
          hi = $urandom_range(255, lo);
        end
        for (int i = 0; i < total; i++) queue_one(i == 0 || i == restart_at, lo, hi);
      end
      rand_items += total;
    end

    // A short frame with an oversized setting that clamps to the maximum.
    wait_drained();
    set_row_length(8191);
    queue_pixels(40, 1'b1, 0, 255);
    wait_accepted();
    wait_drained();

    $display("Streamed %0d pixel words and checked %0d blurred words over %0d row length",
             accepted, results_seen, cfg_writes);
    $display("settings, with clamped lengths, a mid-row shrink, restarts and a long stall.");
    if (err_count == 0 && expected_blur.size() == 0) begin
      $display("rgb_box_blur_17x17_tb: PASS");
    end else begin
      $display("rgb_box_blur_17x17_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/rbb_pkg.sv
src/rbb_position.sv
src/rbb_column_store.sv
src/rbb_window.sv
src/rbb_divide.sv
src/rgb_box_blur_17x17.sv
verif/rgb_box_blur_17x17_tb.sv
